// ----- rtl/core/bde_pkg.sv -----
// Shared types and codes for the button debounce and event detector.
package bde_pkg;

	localparam int CFG_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WIN = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRIPLE_WIN = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LONG       = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VERY_LONG  = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_EXTREME    = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT     = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_MODE = 4'd7;

	localparam logic [1:0] CNT_FALL = 2'd0;
	localparam logic [1:0] CNT_RISE = 2'd1;
	localparam logic [1:0] CNT_BOTH = 2'd2;

	localparam logic [3:0] EV_NONE       = 4'd0;
	localparam logic [3:0] EV_PRESSED    = 4'd1;
	localparam logic [3:0] EV_RELEASED   = 4'd2;
	localparam logic [3:0] EV_SINGLE     = 4'd3;
	localparam logic [3:0] EV_DOUBLE     = 4'd4;
	localparam logic [3:0] EV_TRIPLE     = 4'd5;
	localparam logic [3:0] EV_LONG       = 4'd6;
	localparam logic [3:0] EV_VERY_LONG  = 4'd7;
	localparam logic [3:0] EV_EXTREME    = 4'd8;
	localparam logic [3:0] EV_CLICK_HOLD = 4'd9;
	localparam logic [3:0] EV_RAPID      = 4'd10;

	localparam logic [7:0] CLICK_MAX = 8'd255;

	typedef struct packed {
		logic [15:0] debounce_ms;
		logic [15:0] double_click_window;
		logic [15:0] triple_click_window;
		logic [15:0] long_press_ms;
		logic [15:0] very_long_press_ms;
		logic [15:0] extreme_press_ms;
		logic [15:0] repeat_interval_ms;
		logic [1:0]  count_mode;
	} cfg_t;

	typedef struct packed {
		logic        steady_level;
		logic        press_seen;
		logic        release_seen;
		logic [3:0]  event_code;
		logic [31:0] edge_count;
	} res_t;

endpackage

// ----- rtl/core/bde_cfg.sv -----
// Configuration register file for the button debounce and event detector.
module bde_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bde_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [15:0]                    cfg_data,
	output bde_pkg::cfg_t                  cfg
);

	bde_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms         <= 16'd50;
			cfg_q.double_click_window <= 16'd300;
			cfg_q.triple_click_window <= 16'd500;
			cfg_q.long_press_ms       <= 16'd1000;
			cfg_q.very_long_press_ms  <= 16'd2000;
			cfg_q.extreme_press_ms    <= 16'd5000;
			cfg_q.repeat_interval_ms  <= 16'd100;
			cfg_q.count_mode          <= bde_pkg::CNT_FALL;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bde_pkg::REG_DEBOUNCE:   cfg_q.debounce_ms         <= cfg_data;
				bde_pkg::REG_DOUBLE_WIN: cfg_q.double_click_window <= cfg_data;
				bde_pkg::REG_TRIPLE_WIN: cfg_q.triple_click_window <= cfg_data;
				bde_pkg::REG_LONG:       cfg_q.long_press_ms       <= cfg_data;
				bde_pkg::REG_VERY_LONG:  cfg_q.very_long_press_ms  <= cfg_data;
				bde_pkg::REG_EXTREME:    cfg_q.extreme_press_ms    <= cfg_data;
				bde_pkg::REG_REPEAT:     cfg_q.repeat_interval_ms  <= cfg_data;
				bde_pkg::REG_COUNT_MODE: cfg_q.count_mode          <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/core/bde_core.sv -----
// Debounce, click, hold, rapid-fire and edge-count state with its per-tick update.
module bde_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  logic          raw_level,
	input  logic          ack_event,
	input  logic          clear_count,
	input  logic          clear_pattern,
	input  bde_pkg::cfg_t cfg,
	output bde_pkg::res_t res
);

	logic [31:0] time_q, change_q, press_start_q, first_click_q, repeat_time_q, edge_total_q;
	logic        raw_prev_q, steady_q, before_q, press_flag_q, release_flag_q;
	logic [7:0]  clicks_q;
	logic        awaiting_q, repeat_active_q, press_valid_q;
	logic [2:0]  hold_q;
	logic [3:0]  event_q;

	logic [31:0] t, change_d, press_start_d, first_click_d, repeat_time_d, edge_total_d;
	logic [31:0] dt_click, dt_hold, dt_rel;
	logic        upd, edge_hit, fall, rise;
	logic        steady_d, before_d, press_flag_d, release_flag_d;
	logic [7:0]  clicks_d;
	logic        awaiting_d, repeat_active_d, press_valid_d;
	logic [2:0]  hold_d;
	logic [3:0]  event_d;

	always_comb begin
		t = time_q + 32'd1;
		change_d = (raw_level != raw_prev_q) ? t : change_q;
		upd = (t - change_d) >= {16'd0, cfg.debounce_ms};
		before_d = upd ? steady_q : before_q;
		steady_d = upd ? raw_level : steady_q;
		edge_hit = upd && (steady_q != raw_level);

		event_d = event_q;
		awaiting_d = awaiting_q;
		clicks_d = clicks_q;
		first_click_d = first_click_q;
		hold_d = hold_q;
		repeat_active_d = repeat_active_q;
		repeat_time_d = repeat_time_q;
		press_start_d = press_start_q;
		press_valid_d = press_valid_q;
		press_flag_d = press_flag_q;
		release_flag_d = release_flag_q;
		edge_total_d = edge_total_q;

		dt_click = t - first_click_q;
		if (awaiting_q && clicks_q != 8'd0 && steady_d) begin
			case (clicks_q)
				8'd1: begin
					if (dt_click > {16'd0, cfg.double_click_window}) begin
						event_d = bde_pkg::EV_SINGLE;
						awaiting_d = 1'b0;
						clicks_d = 8'd0;
					end
				end
				8'd2: begin
					if (dt_click <= {16'd0, cfg.double_click_window}) begin
						event_d = bde_pkg::EV_DOUBLE;
						awaiting_d = 1'b0;
						clicks_d = 8'd0;
					end else if (dt_click > {16'd0, cfg.triple_click_window}) begin
						event_d = bde_pkg::EV_SINGLE;
						awaiting_d = 1'b0;
						clicks_d = 8'd0;
					end
				end
				8'd3: begin
					event_d = (dt_click <= {16'd0, cfg.triple_click_window}) ?
						bde_pkg::EV_TRIPLE : bde_pkg::EV_SINGLE;
					awaiting_d = 1'b0;
					clicks_d = 8'd0;
				end
				default: begin
					if (dt_click > {16'd0, cfg.triple_click_window}) begin
						event_d = bde_pkg::EV_SINGLE;
						awaiting_d = 1'b0;
						clicks_d = 8'd0;
					end
				end
			endcase
		end

		dt_hold = t - press_start_q;
		if (!steady_d && press_valid_q) begin
			if (!hold_q[0] && dt_hold >= {16'd0, cfg.long_press_ms}) begin
				event_d = bde_pkg::EV_LONG;
				hold_d[0] = 1'b1;
				awaiting_d = 1'b0;
				clicks_d = 8'd0;
			end else if (!hold_q[1] && dt_hold >= {16'd0, cfg.very_long_press_ms}) begin
				event_d = bde_pkg::EV_VERY_LONG;
				hold_d[1] = 1'b1;
			end else if (!hold_q[2] && dt_hold >= {16'd0, cfg.extreme_press_ms}) begin
				event_d = bde_pkg::EV_EXTREME;
				hold_d[2] = 1'b1;
			end
		end

		if (!steady_d && hold_d[0]) begin
			if (!repeat_active_q) begin
				repeat_active_d = 1'b1;
				repeat_time_d = t;
				event_d = bde_pkg::EV_RAPID;
			end else if ((t - repeat_time_q) >= {16'd0, cfg.repeat_interval_ms}) begin
				repeat_time_d = t;
				event_d = bde_pkg::EV_RAPID;
			end
		end

		fall = edge_hit && !steady_d;
		rise = edge_hit && steady_d;
		dt_rel = t - press_start_q;
		if (fall) begin
			press_flag_d = 1'b1;
			press_start_d = t;
			press_valid_d = 1'b1;
			hold_d = 3'd0;
			event_d = bde_pkg::EV_PRESSED;
			if (clicks_d == 8'd0) begin
				first_click_d = t;
			end
			if (clicks_d < bde_pkg::CLICK_MAX) begin
				clicks_d = clicks_d + 8'd1;
			end
			awaiting_d = 1'b1;
		end
		if (rise) begin
			release_flag_d = 1'b1;
			repeat_active_d = 1'b0;
			event_d = (dt_rel >= {16'd0, cfg.very_long_press_ms}) ?
				bde_pkg::EV_CLICK_HOLD : bde_pkg::EV_RELEASED;
		end
		if ((edge_hit && cfg.count_mode == bde_pkg::CNT_BOTH) ||
		    (fall && cfg.count_mode == bde_pkg::CNT_FALL) ||
		    (rise && cfg.count_mode == bde_pkg::CNT_RISE)) begin
			edge_total_d = edge_total_d + 32'd1;
		end

		res.steady_level = steady_d;
		res.press_seen = press_flag_d;
		res.release_seen = release_flag_d;
		res.event_code = event_d;
		res.edge_count = edge_total_d;

		if (ack_event) begin
			press_flag_d = 1'b0;
			release_flag_d = 1'b0;
			if (event_d >= bde_pkg::EV_SINGLE && event_d <= bde_pkg::EV_CLICK_HOLD) begin
				event_d = bde_pkg::EV_NONE;
			end
		end
		if (clear_count) begin
			edge_total_d = 32'd0;
		end
		if (clear_pattern) begin
			clicks_d = 8'd0;
			first_click_d = 32'd0;
			awaiting_d = 1'b0;
			hold_d = 3'd0;
			repeat_active_d = 1'b0;
			event_d = bde_pkg::EV_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= 32'd0;
			raw_prev_q <= 1'b1;
			change_q <= 32'd0;
			steady_q <= 1'b1;
			before_q <= 1'b1;
			press_flag_q <= 1'b0;
			release_flag_q <= 1'b0;
			press_start_q <= 32'd0;
			first_click_q <= 32'd0;
			clicks_q <= 8'd0;
			awaiting_q <= 1'b0;
			hold_q <= 3'd0;
			repeat_active_q <= 1'b0;
			repeat_time_q <= 32'd0;
			event_q <= bde_pkg::EV_NONE;
			edge_total_q <= 32'd0;
			press_valid_q <= 1'b0;
		end else if (advance) begin
			time_q <= t;
			raw_prev_q <= raw_level;
			change_q <= change_d;
			steady_q <= steady_d;
			before_q <= before_d;
			press_flag_q <= press_flag_d;
			release_flag_q <= release_flag_d;
			press_start_q <= press_start_d;
			first_click_q <= first_click_d;
			clicks_q <= clicks_d;
			awaiting_q <= awaiting_d;
			hold_q <= hold_d;
			repeat_active_q <= repeat_active_d;
			repeat_time_q <= repeat_time_d;
			event_q <= event_d;
			edge_total_q <= edge_total_d;
			press_valid_q <= press_valid_d;
		end
	end

endmodule

// ----- rtl/core/button_debounce_event_detector_unit.sv -----
// Top level of the button debounce and event detector: input stage, core and result register.
//
// Each input transfer is one millisecond tick carrying the raw active-low button level
// and three strobes (ack_event, clear_count, clear_pattern) that act after the tick's
// result is formed. Each tick yields exactly one result transfer with the debounced
// level, the sticky press and release flags, the current event code and the edge count.
// Input and output use valid/stall; a transfer happens when valid is high and stall low.
// Configuration registers are written through cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high, and writes to indexes past the list are dropped.
// A tick passes from the input transfer into the input stage register, and the whole tick
// update then runs in one pass into the result register, which drives out_valid.
// Throughput is one tick per cycle while out_stall does not hold the result register;
// the state update loop completes each tick in one pass.
// When out_stall holds, the result register holds its value and one more tick waits
// in the input stage; in_stall rises only while both are occupied.
// Reset clears all core state to released, zero time and no event, and loads the default
// configuration; no result is pending after reset.
module button_debounce_event_detector_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           raw_level,
	input  logic                           ack_event,
	input  logic                           clear_count,
	input  logic                           clear_pattern,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           steady_level,
	output logic                           press_seen,
	output logic                           release_seen,
	output logic [3:0]                     event_code,
	output logic [31:0]                    edge_count,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bde_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [15:0]                    cfg_data
);

	bde_pkg::cfg_t cfg;
	bde_pkg::res_t res, res_q;

	logic valid_s1, raw_s1, ack_s1, clr_cnt_s1, clr_pat_s1;
	logic out_valid_q;
	logic advance, accept_in;

	assign advance = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign accept_in = in_valid && !in_stall;

	bde_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bde_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.raw_level     (raw_s1),
		.ack_event     (ack_s1),
		.clear_count   (clr_cnt_s1),
		.clear_pattern (clr_pat_s1),
		.cfg           (cfg),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			raw_s1 <= raw_level;
			ack_s1 <= ack_event;
			clr_cnt_s1 <= clear_count;
			clr_pat_s1 <= clear_pattern;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign steady_level = res_q.steady_level;
	assign press_seen = res_q.press_seen;
	assign release_seen = res_q.release_seen;
	assign event_code = res_q.event_code;
	assign edge_count = res_q.edge_count;

endmodule
